// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and the digit-to-ASCII helper for the
// integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned MaxDigits  = 10;

   // floor(u / 10) == (u * Recip10) >> Div10Shift for every 32-bit u
   localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
   localparam int unsigned Div10Shift = 35;

   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharMinus  = 8'h2D;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharUpperA = 8'h41;

   typedef enum logic [1:0] {
      ACT_SIGNED_DEC   = 2'd0,
      ACT_UNSIGNED_DEC = 2'd1,
      ACT_HEX_LOWER    = 2'd2,
      ACT_HEX_UPPER    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIG  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   function automatic logic [7:0] digit_char(input logic [DigitWidth-1:0] d,
                                             input logic upper);
      logic [7:0] base;
      base = upper ? CharUpperA : CharLowerA;
      if (d >= 4'd10) begin
         digit_char = base + {4'd0, d - 4'd10};
      end else begin
         digit_char = CharZero + {4'd0, d};
      end
   endfunction

endpackage

// File: rtl/itoa_div_unit.sv
// ----------------------------------------------------------------------------
// itoa_div_unit
// Shared divide-by-base unit. Decimal uses a registered reciprocal
// multiply; its results are valid in the cycle after u is presented and held.
// ----------------------------------------------------------------------------
module itoa_div_unit
   import itoa_pkg::*;
(
   input  logic                  clock,
   input  logic [ValueWidth-1:0] u,
   input  logic                  hex,
   output logic [ValueWidth-1:0] quot,
   output logic [DigitWidth-1:0] rem
);

   localparam int unsigned QWidth = 2 * ValueWidth - Div10Shift;

   logic [2*ValueWidth-1:0] prod;
   logic [QWidth-1:0]       q10_ff;
   logic [QWidth-1:0]       q10_in;
   logic [ValueWidth-1:0]   q_times10;
   logic [ValueWidth-1:0]   rem10;

   assign prod   = {{ValueWidth{1'b0}}, u} * {{ValueWidth{1'b0}}, Recip10};
   assign q10_in = prod[2*ValueWidth-1:Div10Shift];

   always_ff @(posedge clock) begin
      q10_ff <= q10_in;
   end

   assign q_times10 = ({{(ValueWidth-QWidth){1'b0}}, q10_ff} << 3)
                    + ({{(ValueWidth-QWidth){1'b0}}, q10_ff} << 1);
   assign rem10     = u - q_times10;

   assign quot = hex ? {4'd0, u[ValueWidth-1:4]}
                     : {{(ValueWidth-QWidth){1'b0}}, q10_ff};
   assign rem  = hex ? u[DigitWidth-1:0] : rem10[DigitWidth-1:0];

endmodule

// File: rtl/integer_to_ascii_padded_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_padded_formatter
// Formats one 32-bit integer as signed/unsigned decimal or hex text with
// field width and space/zero padding, one character per output item.
//
//   channel  direction  ports                                    handshake
//   req      in         req_value, req_action, req_field_width,  valid/stall
//                       req_pad_mode
//   rsp      out        rsp_character, rsp_last_char             valid/stall
//
// Sequence: accept, then ST_MUL and ST_DIG per digit in the shared divide unit
// (up to 10 decimal or 8 hex digits), then each character (1..63) out of the
// output register, which rsp_stall can hold.
// Reset: synchronous; clears the sequencer and the output valid.
// req_stall is high from accept until the last character is loaded.
// rsp_stall holds the output register and pauses the character sequence.
// ----------------------------------------------------------------------------
module integer_to_ascii_padded_formatter
   import itoa_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 63
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_field_width,
   input  logic [1:0]  req_pad_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last_char
);

   localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

   state_type state_ff, state_in;

   logic [ValueWidth-1:0] u_ff, u_in;
   logic                  hex_ff, hex_in;
   logic                  upper_ff, upper_in;
   logic                  right_ff, right_in;
   logic                  zero_ff, zero_in;
   logic                  neg_ff, neg_in;
   logic [5:0]            w_ff, w_in;
   logic [3:0]            nd_ff, nd_in;

   logic [DigitWidth-1:0] digits_ff [MaxDigits];

   logic                  lead_ff, lead_in;
   logic                  tsign_ff, tsign_in;
   logic [5:0]            lpad_ff, lpad_in;
   logic [5:0]            rpad_ff, rpad_in;
   logic [3:0]            dig_ff, dig_in;
   logic                  padzero_ff, padzero_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [ValueWidth-1:0] quot;
   logic [DigitWidth-1:0] rem;

   logic                  accept;
   logic                  digit_done;
   logic                  load;
   logic                  pending;
   logic [3:0]            nd_final;
   logic                  sign_first;
   logic [5:0]            w_eff;
   logic [3:0]            len;
   logic [5:0]            padn;
   logic [5:0]            w_sat;
   logic [3:0]            rd_idx;
   logic                  nxt_lead, nxt_tsign;
   logic [5:0]            nxt_lpad, nxt_rpad;
   logic [3:0]            nxt_dig;
   logic [7:0]            cur_char;

   itoa_div_unit u_div (
      .clock (clock),
      .u     (u_ff),
      .hex   (hex_ff),
      .quot  (quot),
      .rem   (rem)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   assign w_sat      = (req_field_width > MaxW) ? MaxW : req_field_width;
   assign digit_done = (state_ff == ST_DIG) && (quot == '0);
   assign nd_final   = nd_ff + 4'd1;
   assign sign_first = neg_ff && (w_ff != 6'd0) && zero_ff;
   assign w_eff      = w_ff - {5'd0, sign_first};
   assign len        = nd_final + {3'd0, neg_ff && !sign_first};
   assign padn       = ({2'd0, len} >= w_eff) ? 6'd0 : (w_eff - {2'd0, len});

   assign pending = lead_ff || tsign_ff || (lpad_ff != 6'd0) || (rpad_ff != 6'd0)
                 || (dig_ff != 4'd0);
   assign load    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rd_idx  = dig_ff - 4'd1;

   always_comb begin
      nxt_lead  = lead_ff;
      nxt_tsign = tsign_ff;
      nxt_lpad  = lpad_ff;
      nxt_rpad  = rpad_ff;
      nxt_dig   = dig_ff;
      if (lead_ff) begin
         cur_char = CharMinus;
         nxt_lead = 1'b0;
      end else if (lpad_ff != 6'd0) begin
         cur_char = padzero_ff ? CharZero : CharSpace;
         nxt_lpad = lpad_ff - 6'd1;
      end else if (tsign_ff) begin
         cur_char  = CharMinus;
         nxt_tsign = 1'b0;
      end else if (dig_ff != 4'd0) begin
         cur_char = digit_char(digits_ff[rd_idx], upper_ff);
         nxt_dig  = dig_ff - 4'd1;
      end else begin
         cur_char = padzero_ff ? CharZero : CharSpace;
         nxt_rpad = rpad_ff - 6'd1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      u_in       = u_ff;
      hex_in     = hex_ff;
      upper_in   = upper_ff;
      right_in   = right_ff;
      zero_in    = zero_ff;
      neg_in     = neg_ff;
      w_in       = w_ff;
      nd_in      = nd_ff;
      lead_in    = lead_ff;
      tsign_in   = tsign_ff;
      lpad_in    = lpad_ff;
      rpad_in    = rpad_ff;
      dig_in     = dig_ff;
      padzero_in = padzero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = (req_action == ACT_SIGNED_DEC) && req_value[31];
               u_in     = ((req_action == ACT_SIGNED_DEC) && req_value[31])
                        ? (32'd0 - req_value) : req_value;
               hex_in   = (req_action == ACT_HEX_LOWER) || (req_action == ACT_HEX_UPPER);
               upper_in = (req_action == ACT_HEX_UPPER);
               right_in = req_pad_mode[0];
               zero_in  = req_pad_mode[1];
               w_in     = w_sat;
               nd_in    = 4'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIG;
         end
         ST_DIG: begin
            u_in  = quot;
            nd_in = nd_final;
            if (digit_done) begin
               lead_in    = sign_first;
               tsign_in   = neg_ff && !sign_first;
               lpad_in    = right_ff ? 6'd0 : padn;
               rpad_in    = right_ff ? padn : 6'd0;
               dig_in     = nd_final;
               padzero_in = zero_ff;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (load) begin
               lead_in  = nxt_lead;
               tsign_in = nxt_tsign;
               lpad_in  = nxt_lpad;
               rpad_in  = nxt_rpad;
               dig_in   = nxt_dig;
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_last_in  = !nxt_lead && !nxt_tsign && (nxt_lpad == 6'd0)
                  && (nxt_rpad == 6'd0) && (nxt_dig == 4'd0);
      rsp_char_in  = load ? cur_char : rsp_char_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lead_ff      <= 1'b0;
         tsign_ff     <= 1'b0;
         lpad_ff      <= 6'd0;
         rpad_ff      <= 6'd0;
         dig_ff       <= 4'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lead_ff      <= lead_in;
         tsign_ff     <= tsign_in;
         lpad_ff      <= lpad_in;
         rpad_ff      <= rpad_in;
         dig_ff       <= dig_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      hex_ff     <= hex_in;
      upper_ff   <= upper_in;
      right_ff   <= right_in;
      zero_ff    <= zero_in;
      neg_ff     <= neg_in;
      w_ff       <= w_in;
      nd_ff      <= nd_in;
      padzero_ff <= padzero_in;
      rsp_char_ff <= rsp_char_in;
      if (load) begin
         rsp_last_ff <= rsp_last_in;
      end
      if (state_ff == ST_DIG) begin
         digits_ff[nd_ff] <= rem;
      end
   end

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL))
      else $error("accepted item did not start digit extraction");

   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> pending)
      else $error("emitting with no characters left");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_last_in) |=> (!pending && (state_ff == ST_IDLE)))
      else $error("last character loaded but sequence not drained");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIG) |-> (nd_ff < 4'(MaxDigits)))
      else $error("digit count overflow");

   a_no_load_outside_emit: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_EMIT))
      else $error("output loaded outside emit phase");
`endif

endmodule
